[rtl/core/flywheel_speed_regulator_macros.svh]
// Assertion macros shared by the flywheel speed regulator RTL.
`ifndef FLYWHEEL_SPEED_REGULATOR_MACROS_SVH
`define FLYWHEEL_SPEED_REGULATOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define FSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define FSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fsr_pkg.sv]
// Package with types, register indexes and constants of the flywheel speed regulator.
`default_nettype none

package fsr_pkg;

  // Field widths
  localparam int SpeedW   = 27;
  localparam int DriveW   = 22;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Register widths
  localparam int GainW   = 24;
  localparam int PoleW   = 17;
  localparam int StaticW = 20;
  localparam int ThreshW = 23;
  localparam int LimitW  = 21;

  // Shared multiplier operand and product widths
  localparam int MulAW = 32;
  localparam int MulBW = 25;
  localparam int ProdW = MulAW + MulBW;
  localparam int FracW = 16;
  localparam int RndW  = ProdW - FracW;
  localparam int SumW  = 44;

  // Register reset values
  localparam logic [PoleW-1:0]  PoleReset  = PoleW'(65536);
  localparam logic [LimitW-1:0] LimitReset = LimitW'(786432);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_FEEDBACK_GAIN      = 3'd0,
    REG_PLANT_POLE         = 3'd1,
    REG_INVERSE_INPUT_GAIN = 3'd2,
    REG_STATIC_VOLTS       = 3'd3,
    REG_SHOT_THRESHOLD     = 3'd4,
    REG_RECOVERY_THRESHOLD = 3'd5,
    REG_VOLT_LIMIT         = 3'd6
  } reg_idx_t;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_FB   = 2'd0,
    MUL_POLE = 2'd1,
    MUL_FF   = 2'd2,
    MUL_NONE = 2'd3
  } mul_sel_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FB   = 5'b00010,
    S_POLE = 5'b00100,
    S_FF   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load_in;
    logic     capture_fb;
    mul_sel_t mul_sel;
    logic     commit;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/fsr_datapath.sv]
// Datapath: configuration registers, loop state, shared multiplier, clamp and hysteresis.
`default_nettype none

module fsr_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fsr_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [fsr_pkg::CfgDataW-1:0]    cfg_data,
  input  logic signed [fsr_pkg::SpeedW-1:0] in_goal_speed,
  input  logic signed [fsr_pkg::SpeedW-1:0] in_measured_speed,
  input  fsr_pkg::cmd_t                   cmd,
  output logic signed [fsr_pkg::DriveW-1:0] out_drive_volts,
  output logic                            out_at_goal,
  output logic                            out_clamped
);
  import fsr_pkg::*;

  // Configuration registers
  logic [GainW-1:0]   gain_r;
  logic [PoleW-1:0]   pole_r;
  logic [GainW-1:0]   inv_gain_r;
  logic [StaticW-1:0] static_r;
  logic [ThreshW-1:0] shot_r;
  logic [ThreshW-1:0] recov_r;
  logic [LimitW-1:0]  limit_r;

  // Transaction and loop state
  logic signed [SpeedW-1:0] goal_r;
  logic signed [SpeedW-1:0] meas_r;
  logic signed [SpeedW-1:0] prev_goal_r;
  logic signed [SpeedW-1:0] ff_goal_r;
  logic                     reached_r;

  // Multiplier and partial results
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_r;
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [RndW-1:0]  rnd;
  logic signed [RndW-1:0]  fb_r;
  logic signed [SpeedW:0]  fb_diff;
  logic signed [30:0]      ff_diff;

  // Final stage signals
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   drive_raw;
  logic signed [SumW-1:0]   drive_lim;
  logic signed [SumW-1:0]   lim_pos;
  logic signed [SumW-1:0]   lim_neg;
  logic                     clamp_hit;
  logic signed [SpeedW:0]   err;
  logic signed [SpeedW+1:0] err_ext;
  logic signed [SpeedW+1:0] shot_ext;
  logic signed [SpeedW+1:0] recov_ext;
  logic                     goal_same;
  logic                     goal_zero;
  logic                     reached_nxt;

  logic signed [DriveW-1:0] drive_out_r;
  logic                     at_goal_out_r;
  logic                     clamped_out_r;

  // Write configuration registers; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= '0;
      pole_r     <= PoleReset;
      inv_gain_r <= '0;
      static_r   <= '0;
      shot_r     <= '0;
      recov_r    <= '0;
      limit_r    <= LimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FEEDBACK_GAIN:      gain_r     <= cfg_data[GainW-1:0];
        REG_PLANT_POLE:         pole_r     <= cfg_data[PoleW-1:0];
        REG_INVERSE_INPUT_GAIN: inv_gain_r <= cfg_data[GainW-1:0];
        REG_STATIC_VOLTS:       static_r   <= cfg_data[StaticW-1:0];
        REG_SHOT_THRESHOLD:     shot_r     <= cfg_data[ThreshW-1:0];
        REG_RECOVERY_THRESHOLD: recov_r    <= cfg_data[ThreshW-1:0];
        REG_VOLT_LIMIT:         limit_r    <= cfg_data[LimitW-1:0];
        default:                ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      goal_r <= in_goal_speed;
      meas_r <= in_measured_speed;
    end
  end

  // Round the registered product half up to Q16.16
  assign prod_rnd = prod_r + ProdW'(32768);
  assign rnd      = prod_rnd[ProdW-1:FracW];

  assign fb_diff = {prev_goal_r[SpeedW-1], prev_goal_r} - {meas_r[SpeedW-1], meas_r};
  assign ff_diff = {{4{goal_r[SpeedW-1]}}, goal_r} - rnd[30:0];

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_FB: begin
        mul_a = {{(MulAW-SpeedW-1){fb_diff[SpeedW]}}, fb_diff};
        mul_b = {1'b0, gain_r};
      end
      MUL_POLE: begin
        mul_a = {{(MulAW-SpeedW){ff_goal_r[SpeedW-1]}}, ff_goal_r};
        mul_b = {{(MulBW-PoleW){1'b0}}, pole_r};
      end
      MUL_FF: begin
        mul_a = {ff_diff[30], ff_diff};
        mul_b = {1'b0, inv_gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register each product, hold the last one while the result waits, and hold the feedback term
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.capture_fb) begin
      fb_r <= rnd;
    end
  end

  // Sum the terms; a zero goal gives zero drive
  assign goal_zero = (goal_r == '0);
  assign sum = {{(SumW-RndW){fb_r[RndW-1]}}, fb_r}
             + {{(SumW-RndW){rnd[RndW-1]}}, rnd}
             + {{(SumW-StaticW){1'b0}}, static_r};
  assign drive_raw = goal_zero ? '0 : sum;

  // Limit the drive to the volt limit
  assign lim_pos = {{(SumW-LimitW){1'b0}}, limit_r};
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (drive_raw > lim_pos) begin
      drive_lim = lim_pos;
      clamp_hit = 1'b1;
    end else if (drive_raw < lim_neg) begin
      drive_lim = lim_neg;
      clamp_hit = 1'b1;
    end else begin
      drive_lim = drive_raw;
      clamp_hit = 1'b0;
    end
  end

  // Update the at-goal flag with hysteresis
  assign goal_same = (goal_r == prev_goal_r);
  assign err       = {goal_r[SpeedW-1], goal_r} - {meas_r[SpeedW-1], meas_r};
  assign err_ext   = {err[SpeedW], err};
  assign shot_ext  = {{(SpeedW+2-ThreshW){1'b0}}, shot_r};
  assign recov_ext = {{(SpeedW+2-ThreshW){1'b0}}, recov_r};

  always_comb begin
    if (goal_same && reached_r) begin
      reached_nxt = !(err_ext > shot_ext);
    end else begin
      reached_nxt = (err_ext < recov_ext);
    end
  end

  // Commit loop state and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_goal_r <= '0;
      ff_goal_r   <= '0;
      reached_r   <= 1'b0;
    end else if (cmd.commit) begin
      prev_goal_r <= goal_r;
      reached_r   <= reached_nxt;
      if (!goal_zero) begin
        ff_goal_r <= goal_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      drive_out_r   <= drive_lim[DriveW-1:0];
      at_goal_out_r <= reached_nxt;
      clamped_out_r <= clamp_hit;
    end
  end

  assign out_drive_volts = drive_out_r;
  assign out_at_goal     = at_goal_out_r;
  assign out_clamped     = clamped_out_r;

endmodule

`default_nettype wire

[rtl/core/fsr_ctrl.sv]
// Controller: sequences the shared multiplier and owns the handshakes.
`default_nettype none

module fsr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output fsr_pkg::cmd_t cmd
);
  import fsr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Advance through the three products, then commit when the result slot frees
  always_comb begin
    state_nxt      = state_r;
    cmd.load_in    = 1'b0;
    cmd.capture_fb = 1'b0;
    cmd.mul_sel    = MUL_NONE;
    cmd.commit     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_in = accept;
        if (accept) state_nxt = S_FB;
      end
      S_FB: begin
        cmd.mul_sel = MUL_FB;
        state_nxt   = S_POLE;
      end
      S_POLE: begin
        cmd.mul_sel    = MUL_POLE;
        cmd.capture_fb = 1'b1;
        state_nxt      = S_FF;
      end
      S_FF: begin
        cmd.mul_sel = MUL_FF;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.commit = slot_free;
        if (slot_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result valid until it is taken
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/core/flywheel_speed_regulator.sv]
// Flywheel speed regulator: LQR feedback plus plant-inversion feedforward.
//
// Usage: each input transaction (in_valid, in_stall) carries one control tick:
// goal and measured speed, signed Q16.16. Each tick yields one result
// transaction (out_valid, out_stall): the limited drive voltage, the at-goal
// flag and the clamp flag. Registers are written through cfg_we, cfg_index and
// cfg_data while no tick is in flight; indexes past the list are ignored.
// The single shared multiplier forms the feedback, plant-pole and feedforward
// products in successive cycles, and the final state sums, limits and commits.
// One tick is worked on at a time and the input reopens in the cycle after the
// commit, so a new tick is taken only once the last one has committed.
// While a result waits under out_stall, the next tick is accepted and computed;
// it commits only once the waiting result is taken, and in_stall stays high
// meanwhile.
// Reset: synchronous on rst_n low; registers return to their defaults (pole 1.0,
// volt limit 12.0, others zero) and the loop state and at-goal flag clear.
`default_nettype none

`include "flywheel_speed_regulator_macros.svh"

module flywheel_speed_regulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fsr_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [fsr_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fsr_pkg::SpeedW-1:0]   in_goal_speed,
  input  logic signed [fsr_pkg::SpeedW-1:0]   in_measured_speed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fsr_pkg::DriveW-1:0]   out_drive_volts,
  output logic                                out_at_goal,
  output logic                                out_clamped
);
  import fsr_pkg::*;

  cmd_t cmd;

  fsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fsr_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_goal_speed     (in_goal_speed),
    .in_measured_speed (in_measured_speed),
    .cmd               (cmd),
    .out_drive_volts   (out_drive_volts),
    .out_at_goal       (out_at_goal),
    .out_clamped       (out_clamped)
  );

  // A commit never overwrites a result that is still waiting
  `FSR_ASSERT_NOW(a_commit_slot_free, cmd.commit, !out_valid || !out_stall, "commit over held result")
  // An accepted transaction blocks the input on the next cycle
  `FSR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open while busy")
  // The feedback term is captured right after the feedback product
  `FSR_ASSERT_NEXT(a_fb_then_capture, cmd.mul_sel == MUL_FB, cmd.capture_fb, "feedback capture lost")

endmodule

`default_nettype wire

[sim/tb_flywheel_speed_regulator.sv]
// Self-checking testbench for the flywheel speed regulator.
`default_nettype none

module tb_flywheel_speed_regulator;
  import fsr_pkg::*;

  // Run shape
  localparam int NumRegs       = REG_VOLT_LIMIT + 1;
  localparam int NumSteps      = 25;
  localparam int NumPhases     = 7;
  localparam int ItemsPerPhase = 232;
  localparam int TailCycles    = 8;
  localparam int EndCycles     = 20;
  localparam int HoldCycles    = 300;
  localparam int SqueezeItems  = 40;
  localparam int unsigned CycleLimit = 1000000;

  // Fixed-point constants
  localparam longint QOne    = 65536;
  localparam longint HalfLsb = 32768;

  // Index past the register list; writes to it are dropped
  localparam logic [CfgIdxW-1:0] REG_NONE = 3'd7;

  localparam logic signed [SpeedW-1:0] SpeedMax = {1'b0, {(SpeedW-1){1'b1}}};
  localparam logic signed [SpeedW-1:0] SpeedMin = {1'b1, {(SpeedW-1){1'b0}}};
  localparam logic [CfgDataW-1:0]      AllOnes  = '1;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     at_goal;
    logic                     clamped;
  } tick_result_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CfgIdxW-1:0]       reg_sel;
    logic [CfgDataW-1:0]      reg_data;
    logic signed [SpeedW-1:0] goal;
    logic signed [SpeedW-1:0] meas;
    logic                     known;
    tick_result_t             given;
  } step_row_t;

  typedef enum logic [2:0] {
    PROF_TYPICAL,
    PROF_ONES,
    PROF_ZERO,
    PROF_WILD,
    PROF_NO_DRIVE
  } profile_t;

  // DUT ports
  logic                     clk;
  logic                     rst_n             = 1'b0;
  logic                     cfg_we            = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index         = '0;
  logic [CfgDataW-1:0]      cfg_data          = '0;
  logic                     in_valid          = 1'b0;
  logic                     in_stall;
  logic signed [SpeedW-1:0] in_goal_speed     = '0;
  logic signed [SpeedW-1:0] in_measured_speed = '0;
  logic                     out_valid;
  logic                     out_stall         = 1'b1;
  logic signed [DriveW-1:0] out_drive_volts;
  logic                     out_at_goal;
  logic                     out_clamped;

  // Shadow registers and loop state of the regulator
  longint gain_q     = 0;
  longint pole_q     = PoleReset;
  longint inv_gain_q = 0;
  longint static_q   = 0;
  longint shot_q     = 0;
  longint recover_q  = 0;
  longint limit_q    = LimitReset;
  longint last_goal  = 0;
  longint ff_goal    = 0;
  logic   on_speed   = 1'b0;

  tick_result_t pending_results[$];
  int           mismatch_count = 0;
  int unsigned  cycle_count    = 0;

  // Sender and receiver pacing
  int   calm_left   = 0;
  logic squeeze_req = 1'b0;
  int   hold_left   = 0;
  int   stall_left  = 0;
  int   free_left   = 0;
  int   stall_pick;

  flywheel_speed_regulator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_goal_speed     (in_goal_speed),
    .in_measured_speed (in_measured_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_volts   (out_drive_volts),
    .out_at_goal       (out_at_goal),
    .out_clamped       (out_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q16.16 value times Q16.16 gain, rounded half up
  function automatic longint scale_q16(longint a, longint g);
    return (a * g + HalfLsb) >>> 16;
  endfunction

  // Compute one control tick and advance the loop state
  function automatic tick_result_t regulate_tick(logic signed [SpeedW-1:0] goal_in,
                                                 logic signed [SpeedW-1:0] meas_in);
    longint goal, meas, drive, speed_err;
    tick_result_t r;
    goal  = goal_in;
    meas  = meas_in;
    drive = 0;
    r.clamped = 1'b0;
    if (goal != last_goal) on_speed = 1'b0;
    if (goal != 0) begin
      drive = scale_q16(last_goal - meas, gain_q)
            + scale_q16(goal - scale_q16(ff_goal, pole_q), inv_gain_q)
            + static_q;
      ff_goal = goal;
    end
    // limit the drive magnitude
    if (drive > limit_q) begin
      drive = limit_q;
      r.clamped = 1'b1;
    end else if (drive < -limit_q) begin
      drive = -limit_q;
      r.clamped = 1'b1;
    end
    // at-goal hysteresis on the signed speed error
    speed_err = goal - meas;
    if (on_speed && speed_err > shot_q) on_speed = 1'b0;
    else if (!on_speed && speed_err < recover_q) on_speed = 1'b1;
    last_goal = goal;
    r.drive   = drive[DriveW-1:0];
    r.at_goal = on_speed;
    return r;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] sel, logic [CfgDataW-1:0] data);
    case (sel)
      REG_FEEDBACK_GAIN:      gain_q     = data[GainW-1:0];
      REG_PLANT_POLE:         pole_q     = data[PoleW-1:0];
      REG_INVERSE_INPUT_GAIN: inv_gain_q = data[GainW-1:0];
      REG_STATIC_VOLTS:       static_q   = data[StaticW-1:0];
      REG_SHOT_THRESHOLD:     shot_q     = data[ThreshW-1:0];
      REG_RECOVERY_THRESHOLD: recover_q  = data[ThreshW-1:0];
      REG_VOLT_LIMIT:         limit_q    = data[LimitW-1:0];
      default: ;
    endcase
  endfunction

  function automatic step_row_t tick_row(logic signed [SpeedW-1:0] goal,
                                         logic signed [SpeedW-1:0] meas);
    step_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.goal = goal;
    row.meas = meas;
    return row;
  endfunction

  function automatic step_row_t known_row(logic signed [SpeedW-1:0] goal,
                                          logic signed [SpeedW-1:0] meas,
                                          logic signed [DriveW-1:0] drive,
                                          logic at_goal, logic clamped);
    step_row_t row;
    row = tick_row(goal, meas);
    row.known = 1'b1;
    row.given.drive   = drive;
    row.given.at_goal = at_goal;
    row.given.clamped = clamped;
    return row;
  endfunction

  function automatic step_row_t reg_row(logic [CfgIdxW-1:0] sel, logic [CfgDataW-1:0] data);
    step_row_t row;
    row = '0;
    row.kind     = ROW_REG;
    row.reg_sel  = sel;
    row.reg_data = data;
    return row;
  endfunction

  // Sender gap: mostly short, a few long, with calm runs of back-to-back items
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one tick, hold it until accepted, then record its expected result
  task automatic send_tick(input logic signed [SpeedW-1:0] goal,
                           input logic signed [SpeedW-1:0] meas,
                           input logic known, input tick_result_t given);
    int gap;
    tick_result_t model_out;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_goal_speed     <= goal;
    in_measured_speed <= meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_out = regulate_tick(goal, meas);
    pending_results.push_back(known ? given : model_out);
  endtask

  // Drop valid and wait until the block has nothing in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] sel, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(sel, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write all registers from one setting profile
  task automatic load_profile(input profile_t prof);
    reg_idx_t            ri;
    logic [CfgDataW-1:0] v;
    for (int i = 0; i < NumRegs; i++) begin
      ri = reg_idx_t'(i);
      case (prof)
        PROF_ONES: v = AllOnes;
        PROF_ZERO: v = '0;
        PROF_WILD: v = CfgDataW'($urandom);
        default: begin
          case (ri)
            REG_FEEDBACK_GAIN:      v = $urandom_range(0, 4 * QOne);
            REG_PLANT_POLE:         v = $urandom_range(58982, QOne);
            REG_INVERSE_INPUT_GAIN: v = $urandom_range(0, 3 * QOne);
            REG_STATIC_VOLTS:       v = $urandom_range(0, 786432);
            REG_SHOT_THRESHOLD:     v = $urandom_range(0, 6553600);
            REG_RECOVERY_THRESHOLD: v = $urandom_range(0, 6553600);
            default:                v = $urandom_range(0, 1048576);
          endcase
        end
      endcase
      if (prof == PROF_NO_DRIVE && ri == REG_VOLT_LIMIT) v = '0;
      write_reg(ri, v);
    end
    if (prof == PROF_WILD) write_reg(REG_NONE, CfgDataW'($urandom));
  endtask

  // Stimulus: reset, directed table, then random phases
  initial begin : stimulus
    step_row_t                directed_steps [NumSteps];
    profile_t                 phase_plan [NumPhases];
    logic signed [SpeedW-1:0] goal, meas;
    logic signed [SpeedW-1:0] sent_goal;
    int                       r, span, off;

    directed_steps = '{
      // reset settings give zero drive; only the at-goal flag moves
      known_row(0, 0, 0, 1'b0, 1'b0),
      known_row(0, 1, 0, 1'b1, 1'b0),
      known_row(0, -1, 0, 1'b0, 1'b0),
      known_row(SpeedMax, SpeedMax, 0, 1'b0, 1'b0),
      known_row(SpeedMin, SpeedMax, 0, 1'b1, 1'b0),
      known_row(SpeedMin, SpeedMin, 0, 1'b1, 1'b0),
      // unit gains, half a volt of static friction
      reg_row(REG_FEEDBACK_GAIN, QOne),
      reg_row(REG_INVERSE_INPUT_GAIN, QOne),
      reg_row(REG_STATIC_VOLTS, HalfLsb),
      tick_row(QOne, 0),
      tick_row(QOne, QOne),
      tick_row(0, 12345),
      // every register at all ones, masked to its width; pole above 1.0
      reg_row(REG_FEEDBACK_GAIN, AllOnes),
      reg_row(REG_PLANT_POLE, AllOnes),
      reg_row(REG_INVERSE_INPUT_GAIN, AllOnes),
      reg_row(REG_STATIC_VOLTS, AllOnes),
      reg_row(REG_SHOT_THRESHOLD, AllOnes),
      reg_row(REG_RECOVERY_THRESHOLD, AllOnes),
      reg_row(REG_VOLT_LIMIT, AllOnes),
      reg_row(REG_NONE, AllOnes),
      tick_row(SpeedMax, SpeedMin),
      tick_row(SpeedMin, SpeedMax),
      // zero volt limit forces zero drive
      reg_row(REG_VOLT_LIMIT, '0),
      tick_row(QOne, QOne),
      tick_row(0, 0)
    };
    phase_plan = '{PROF_TYPICAL, PROF_ONES, PROF_TYPICAL, PROF_ZERO,
                   PROF_WILD, PROF_NO_DRIVE, PROF_TYPICAL};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_REG) begin
        settle();
        write_reg(directed_steps[i].reg_sel, directed_steps[i].reg_data);
      end else begin
        send_tick(directed_steps[i].goal, directed_steps[i].meas,
                  directed_steps[i].known, directed_steps[i].given);
      end
    end

    // random phases, each under its own register setting
    sent_goal = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      load_profile(phase_plan[ph]);
      if (phase_plan[ph] == PROF_TYPICAL && ph > 0) begin
        squeeze_req <= 1'b1;
        calm_left = SqueezeItems;
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // goal: mostly held so the at-goal flag can settle
        r = $urandom_range(0, 99);
        if (r < 55) goal = sent_goal;
        else if (r < 65) goal = 0;
        else if (r < 88) goal = SpeedW'(int'($urandom_range(0, 13107200)) - 6553600);
        else goal = SpeedW'($urandom);
        // measured: mostly near the goal, around the thresholds
        r = $urandom_range(0, 99);
        span = int'((shot_q > recover_q ? shot_q : recover_q) + QOne);
        if (r < 70) begin
          off  = int'($urandom_range(0, 2 * span)) - span;
          meas = SpeedW'(int'(goal) + off);
        end else if (r < 85) begin
          meas = goal;
        end else begin
          meas = SpeedW'($urandom);
        end
        send_tick(goal, meas, 1'b0, '0);
        sent_goal = goal;
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (EndCycles) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Receiver stall: random gaps, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze_req) begin
      out_stall   <= 1'b1;
      hold_left   <= HoldCycles;
      squeeze_req <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left <= free_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        free_left <= $urandom_range(0, 30);
      end else if (stall_pick < 90) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(8, 50);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no tick waiting: drive_volts %0d", out_drive_volts);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_drive_volts !== want.drive) begin
          $error("drive_volts: expected %0d, actual %0d", want.drive, out_drive_volts);
          mismatch_count++;
        end
        if (out_at_goal !== want.at_goal) begin
          $error("at_goal: expected %0b, actual %0b", want.at_goal, out_at_goal);
          mismatch_count++;
        end
        if (out_clamped !== want.clamped) begin
          $error("clamped: expected %0b, actual %0b", want.clamped, out_clamped);
          mismatch_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire

[flywheel_speed_regulator.f]
+incdir+rtl/core
rtl/core/fsr_pkg.sv
rtl/core/fsr_datapath.sv
rtl/core/fsr_ctrl.sv
rtl/core/flywheel_speed_regulator.sv
sim/tb_flywheel_speed_regulator.sv
